@@ design/rfps_pkg.sv @@
// Shared types, constants and helper function of the rarest-first piece selector.
`timescale 1ns / 1ps

package rfps_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_INCR   = 2'd2,
    ACT_SELECT = 2'd3
  } action_t;

  localparam logic CFG_PIECE_LIMIT = 1'b0;
  localparam logic CFG_RANDOM_SEED = 1'b1;

  localparam int LFSR_BITS = 16;
  localparam int TIE_BITS  = 13;
  localparam int IDX_BITS  = 12;
  localparam int NP_BITS   = 13;

  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [TIE_BITS-1:0]  TIES_MAX  = 13'd8191;

  // Remainder unit: quotient bits retired per cycle and the resulting cycle count.
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = LFSR_BITS / DIV_STEP_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic                 valid;
    logic [LFSR_BITS-1:0] dividend;
    logic [TIE_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic active;
    logic done;
    logic rem_zero;
  } div_rsp_t;

  // Galois step, shift right with tap mask on the dropped bit.
  function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] cur);
    logic [LFSR_BITS-1:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

@@ design/rfps_divider.sv @@
// Multi-cycle remainder unit: LFSR value modulo tie count, DIV_STEP_BITS quotient bits per cycle.
`timescale 1ns / 1ps

module rfps_divider (
  input  logic              clk,
  input  logic              rst,
  input  rfps_pkg::div_req_t req,
  output rfps_pkg::div_rsp_t rsp
);
  import rfps_pkg::*;

  logic                    active;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [LFSR_BITS-1:0]    quo;
  logic [TIE_BITS-1:0]     divisor;
  logic [TIE_BITS-1:0]     rem;
  logic [LFSR_BITS-1:0]    quo_next;
  logic [TIE_BITS-1:0]     rem_next;

  // Restoring steps: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    logic [TIE_BITS:0] trial;
    logic [TIE_BITS-1:0] r;
    logic [LFSR_BITS-1:0] q;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {r, q[LFSR_BITS-1]};
      q     = q << 1;
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      r = trial[TIE_BITS-1:0];
    end
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.valid) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      quo     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (active) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.active   = active;
  assign rsp.done     = done;
  assign rsp.rem_zero = (rem == '0);

endmodule

@@ design/rarest_first_piece_selector.sv @@
// Top level of the rarest-first piece selector: count table, scan state and result register.
`timescale 1ns / 1ps
// Flow: a request is read from the count table at accept and finishes in the cycle after;
//   a closing select request reports on done through the result register, after the
//   remainder unit on a tie. Throughput: one request per cycle while busy is low; a tie on
//   the current minimum holds busy while the remainder unit retires four quotient bits a cycle.
// Reset: synchronous; afterwards a clearing pass zeroes the count table, one entry per
//   cycle, with busy high. The receiver cannot stall results.

module rarest_first_piece_selector #(
  parameter int MAX_PIECES = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [11:0] piece_num,
  input  logic        peer_has,
  input  logic        client_has,
  input  logic        scan_last,
  output logic        done,
  output logic        found,
  output logic [11:0] chosen_piece,
  output logic [15:0] rarest_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rfps_pkg::*;

  localparam int AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Configuration
  logic [NP_BITS-1:0]   pieces_used;
  logic [LFSR_BITS-1:0] tie_lfsr;

  // Count table, clearing pass and one-deep write forward
  logic [COUNT_BITS-1:0] counts [MAX_PIECES];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  clr_active;
  logic [AW-1:0]         clr_addr;
  logic                  fwd_valid;
  logic [AW-1:0]         fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // Request held for its table read
  logic              s1_valid;
  action_t           s1_action;
  logic [AW-1:0]     s1_addr;
  logic [IDX_BITS-1:0] s1_idx;
  logic              s1_ok;
  logic              s1_peer;
  logic              s1_client;
  logic              s1_last;

  // Scan state
  logic                  scan_any,    scan_any_next;
  logic [COUNT_BITS-1:0] scan_min,    scan_min_next;
  logic [IDX_BITS-1:0]   scan_choice, scan_choice_next;
  logic [TIE_BITS-1:0]   scan_ties,   scan_ties_next;
  logic [LFSR_BITS-1:0]  tie_lfsr_next;

  // Tie held while the remainder unit works
  logic [IDX_BITS-1:0] div_idx;
  logic                div_last;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept;
  logic [AW-1:0]       in_addr;
  logic [15:0]         idx_wide;
  logic [16:0]         lim;
  logic                in_ok;
  logic [COUNT_BITS-1:0] cur;
  logic                eligible;
  logic                tie_now;

  logic                emit;
  logic                found_next;
  logic [IDX_BITS-1:0] chosen_next;
  logic [15:0]         count_next;
  logic [31:0]         min_wide;

  rfps_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Accept side: range check against min(pieces_used, MAX_PIECES) and table address.
  assign idx_wide = {4'b0, piece_num};
  assign in_addr  = idx_wide[AW-1:0];
  assign lim      = ({4'b0, pieces_used} < 17'(MAX_PIECES)) ? {4'b0, pieces_used}
                                                            : 17'(MAX_PIECES);
  assign in_ok    = ({5'b0, piece_num} < lim);

  // Count value as seen after the previous request's write.
  assign cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;

  assign eligible = s1_valid && (s1_action == ACT_SELECT) && s1_ok && s1_peer && !s1_client;
  assign tie_now  = eligible && scan_any && (cur == scan_min);

  // Hold requests off while clearing, while a tie is resolving, and on the cycle a tie is seen.
  assign busy   = clr_active || div_rsp.active || tie_now;
  assign accept = start && !busy;

  // Count update for the clearing pass and for add, remove and increment requests.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = cur;
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (s1_valid && s1_ok) begin
      case (s1_action)
        ACT_ADD: begin
          if (s1_peer && (cur != CNT_MAX)) begin
            mem_we    = 1'b1;
            mem_wdata = cur + 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (s1_peer && (cur != '0)) begin
            mem_we    = 1'b1;
            mem_wdata = cur - 1'b1;
          end
        end
        ACT_INCR: begin
          if (cur != CNT_MAX) begin
            mem_we    = 1'b1;
            mem_wdata = cur + 1'b1;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Scan update, tie launch and result formation.
  always_comb begin
    scan_any_next    = scan_any;
    scan_min_next    = scan_min;
    scan_choice_next = scan_choice;
    scan_ties_next   = scan_ties;
    tie_lfsr_next    = tie_lfsr;
    div_req          = '0;
    emit             = 1'b0;

    if (eligible) begin
      if (!scan_any || (cur < scan_min)) begin
        // New minimum: restart the reservoir with this piece.
        scan_any_next    = 1'b1;
        scan_min_next    = cur;
        scan_choice_next = s1_idx;
        scan_ties_next   = TIE_BITS'(1);
      end else if (cur == scan_min) begin
        // Tie: bump the tie count unless saturated, step the LFSR and resolve the swap in the remainder unit.
        if (scan_ties < TIES_MAX) begin
          scan_ties_next = scan_ties + 1'b1;
        end
        tie_lfsr_next    = lfsr_step(tie_lfsr);
        div_req.valid    = 1'b1;
        div_req.dividend = tie_lfsr_next;
        div_req.divisor  = scan_ties_next;
      end
    end

    if (s1_valid && (s1_action == ACT_SELECT) && s1_last && !tie_now) begin
      emit = 1'b1;
    end

    if (div_rsp.done) begin
      if (div_rsp.rem_zero) begin
        scan_choice_next = div_idx;
      end
      emit = div_last;
    end

    min_wide    = 32'(scan_min_next);
    found_next  = scan_any_next;
    chosen_next = scan_any_next ? scan_choice_next : '0;
    count_next  = scan_any_next ? min_wide[15:0] : 16'd0;

    // Close the scan once its result is taken.
    if (emit) begin
      scan_any_next    = 1'b0;
      scan_min_next    = CNT_MAX;
      scan_choice_next = '0;
      scan_ties_next   = '0;
    end
  end

  // Count table: registered read at accept, one write port.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= counts[in_addr];
    end
    if (mem_we) begin
      counts[mem_waddr] <= mem_wdata;
    end
  end

  // Forward the write that lands on the same edge as the next read.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= mem_waddr;
    fwd_data <= mem_wdata;
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MAX_PIECES - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action_t'(action);
      s1_addr   <= in_addr;
      s1_idx    <= piece_num;
      s1_ok     <= in_ok;
      s1_peer   <= peer_has;
      s1_client <= client_has;
      s1_last   <= scan_last;
    end
  end

  // Configuration and scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pieces_used <= NP_BITS'(4096);
      tie_lfsr    <= LFSR_BITS'(1);
      scan_any    <= 1'b0;
      scan_min    <= CNT_MAX;
      scan_choice <= '0;
      scan_ties   <= '0;
    end else begin
      scan_any    <= scan_any_next;
      scan_min    <= scan_min_next;
      scan_choice <= scan_choice_next;
      scan_ties   <= scan_ties_next;
      if (cfg_we && (cfg_index == CFG_RANDOM_SEED)) begin
        // A zero seed would lock the LFSR; load one instead.
        tie_lfsr <= (cfg_data != '0) ? cfg_data : LFSR_BITS'(1);
      end else begin
        tie_lfsr <= tie_lfsr_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIECE_LIMIT: begin
            pieces_used <= cfg_data[NP_BITS-1:0];
          end
          default: begin
            pieces_used <= pieces_used;
          end
        endcase
      end
    end
  end

  // Hold the tied piece until its swap is decided.
  always_ff @(posedge clk) begin
    if (div_req.valid) begin
      div_idx  <= s1_idx;
      div_last <= s1_last;
    end
  end

  // Result register: one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found        <= found_next;
      chosen_piece <= chosen_next;
      rarest_count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_launch_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.valid |-> !div_rsp.active && !div_rsp.done)
    else $error("tie launched while remainder unit busy");

  a_no_accept_on_tie: assert property (@(posedge clk) disable iff (rst)
    div_req.valid |=> !s1_valid)
    else $error("request accepted on a tie cycle");

  a_scan_closed_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !scan_any && (scan_ties == '0))
    else $error("scan state not cleared after result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> (chosen_piece == '0) && (rarest_count == '0))
    else $error("empty scan reported a piece");

  a_ties_nonzero: assert property (@(posedge clk) disable iff (rst)
    scan_any |-> (scan_ties != '0))
    else $error("active scan with zero tie count");
`endif

endmodule
